// ===== rtl/core/utf8_sanitize_bounded_copy_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 sanitizing bounded copy: assertion macros
// Concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef UTF8_SANITIZE_BOUNDED_COPY_DEFINES_SVH
`define UTF8_SANITIZE_BOUNDED_COPY_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define UTF8SBC_ASSERT_SAME(label, ck, rn, cond, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (prop)) \
        else $error(msg);
`define UTF8SBC_ASSERT_NEXT(label, ck, rn, cond, prop, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define UTF8SBC_ASSERT_SAME(label, ck, rn, cond, prop, msg)
`define UTF8SBC_ASSERT_NEXT(label, ck, rn, cond, prop, msg)
`endif

`endif

// ===== rtl/core/utf8sbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizing bounded copy: shared package
// Result packet type passed from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
package utf8sbc_pkg;

    localparam int unsigned MAX_RESULTS     = 5;
    localparam int unsigned CNT_W           = 3;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // All result bytes caused by one input item.
    typedef struct packed {
        logic [CNT_W-1:0]                 cnt;
        logic [MAX_RESULTS-1:0][7:0]      bytes;
        logic [MAX_RESULTS-1:0]           last;
    } packet_t;

    typedef struct packed {
        logic    valid;
        packet_t pkt;
    } pkt_slot_t;

endpackage

// ===== rtl/core/utf8_sanitize_bounded_copy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizing bounded copy: top level
// Copies a byte stream into a bounded output, replacing broken UTF-8 with '?'.
// ----------------------------------------------------------------------------
// Usage:
//   Text channel (text_valid/text_stall) carries one source byte per item, or
//   a bare end marker, with end_of_text on the final item of a string.
//   Result channel (res_valid/res_stall) carries out_byte, with out_last set
//   on the zero terminator. Each text item causes zero to five result items.
//   The user writes the capacity register through cfg_valid/cfg_ready while
//   the block is idle (not enforced by the block); cfg_ready is always high.
// Timing:
//   One text item is accepted per cycle while text_stall is low. Its results
//   go through the packet queue into the output register, and the back end
//   sends one result per cycle while res_stall is low. The packet queue
//   between front and back ends (QUEUE_DEPTH items) sets how long the text
//   side keeps accepting while results are held back.
// Reset and stall:
//   Reset sets capacity to 256 and clears parser counters and queue pointers.
//   A stalled result holds its value; once the queue fills, text_stall rises.
// ----------------------------------------------------------------------------
`include "utf8_sanitize_bounded_copy_defines.svh"

module utf8_sanitize_bounded_copy
    import utf8sbc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        text_valid,
    output logic        text_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_text,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [7:0]  out_byte,
    output logic        out_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_capacity
);

    pkt_slot_t push;
    pkt_slot_t head;
    logic      q_full;
    logic      pop;
    logic      accept;

    assign text_stall = q_full;
    assign accept     = text_valid && !q_full;
    assign cfg_ready  = 1'b1;

    utf8sbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .end_of_text  (end_of_text),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_capacity (cfg_capacity),
        .push         (push)
    );

    utf8sbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    utf8sbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    `UTF8SBC_ASSERT_SAME(a_no_push_full, clk, rst_n, push.valid, !q_full,
        "push into full queue")
    `UTF8SBC_ASSERT_SAME(a_pop_nonempty, clk, rst_n, pop, head.valid,
        "pop from empty queue")
    `UTF8SBC_ASSERT_SAME(a_push_count, clk, rst_n, push.valid,
        (push.pkt.cnt != '0) && (push.pkt.cnt <= CNT_W'(MAX_RESULTS)),
        "bad packet size")
    `UTF8SBC_ASSERT_NEXT(a_pop_frees, clk, rst_n, pop && !push.valid, !q_full,
        "queue still full after pop")

endmodule

// ===== rtl/core/utf8sbc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizing bounded copy: front end
// Accepts one item per cycle while accept is high, runs the UTF-8 parser and
// buffer bound check, and hands any results of an item as one queue packet.
// ----------------------------------------------------------------------------
module utf8sbc_front
    import utf8sbc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_text,
    input  logic        cfg_write,
    input  logic [15:0] cfg_capacity,
    output pkt_slot_t   push
);

    localparam logic [15:0] CAPACITY_RESET = 16'd256;
    localparam logic [7:0]  REPL_CHAR      = 8'h3F;
    localparam logic [7:0]  CONT_MASK      = 8'hC0;
    localparam logic [7:0]  CONT_CODE      = 8'h80;
    localparam logic [7:0]  LEAD2_MASK     = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE     = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK     = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE     = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK     = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE     = 8'hF0;

    // Working state while one item is processed; room is the number of text
    // bytes still allowed before the terminator, saturated at seven.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] ob;
        logic [MAX_RESULTS-1:0]      ol;
        logic [CNT_W-1:0]            cnt;
        logic [2:0]                  room;
        logic [2:0]                  nemit;
        logic                        stop;
        logic [1:0]                  pc;
        logic [2:0]                  el;
        logic [2:0][7:0]             pb;
    } work_t;

    logic [15:0]     cap_reg, cap_next;
    logic [15:0]     wc_reg, wc_next;
    logic [16:0]     room_reg, room_next;
    logic            stopped_reg, stopped_next;
    logic [1:0]      pc_reg, pc_next;
    logic [2:0]      el_reg, el_next;
    logic [2:0][7:0] pb_reg, pb_next;

    logic [2:0]      room_sat;
    logic            clr;
    work_t           w;

    function automatic work_t f_put(work_t wi, logic [7:0] b, logic last);
        work_t wo;
        wo = wi;
        if (wo.cnt < CNT_W'(MAX_RESULTS)) begin
            wo.ob[wo.cnt] = b;
            wo.ol[wo.cnt] = last;
            wo.cnt        = wo.cnt + 1'b1;
        end
        return wo;
    endfunction

    function automatic work_t f_terminate(work_t wi);
        work_t wo;
        wo      = f_put(wi, 8'h00, 1'b1);
        wo.stop = 1'b1;
        wo.pc   = 2'd0;
        wo.el   = 3'd0;
        return wo;
    endfunction

    function automatic work_t f_emit(work_t wi, logic [7:0] b);
        work_t wo;
        wo       = f_put(wi, b, 1'b0);
        wo.nemit = wo.nemit + 3'd1;
        wo.room  = wo.room - 3'd1;
        if (wo.room == 3'd0) begin
            wo = f_terminate(wo);
        end
        return wo;
    endfunction

    function automatic work_t f_take_lead(work_t wi, logic [7:0] b);
        work_t wo;
        wo = wi;
        if (!b[7]) begin
            wo = f_emit(wo, b);
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
            wo.el    = 3'd2;
            wo.pb[0] = b;
            wo.pc    = 2'd1;
        end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
            wo.el    = 3'd3;
            wo.pb[0] = b;
            wo.pc    = 2'd1;
        end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
            wo.el    = 3'd4;
            wo.pb[0] = b;
            wo.pc    = 2'd1;
        end else begin
            wo = f_emit(wo, REPL_CHAR);
        end
        return wo;
    endfunction

    // A held partial sequence becomes one replacement per held byte.
    function automatic work_t f_flush(work_t wi);
        work_t      wo;
        logic [1:0] n;
        int         i;
        wo    = wi;
        n     = wo.pc;
        wo.pc = 2'd0;
        wo.el = 3'd0;
        for (i = 0; i < 3; i++) begin
            if ((2'(i) < n) && !wo.stop) begin
                wo = f_emit(wo, REPL_CHAR);
            end
        end
        return wo;
    endfunction

    function automatic work_t f_take_byte(work_t wi, logic [7:0] b);
        work_t           wo;
        logic            complete;
        logic [2:0][7:0] held;
        logic [1:0]      n;
        logic [2:0]      k;
        int              i;
        wo       = wi;
        complete = 1'b0;
        if (wo.pc == 2'd0) begin
            wo = f_take_lead(wo, b);
        end else if ((b & CONT_MASK) == CONT_CODE) begin
            // A four-byte sequence keeps only three bytes; the last one
            // completes it straight from the input.
            if ((wo.el == 3'd4) && (wo.pc == 2'd3)) begin
                complete = 1'b1;
            end else begin
                wo.pb[wo.pc] = b;
                wo.pc        = wo.pc + 2'd1;
                complete     = ({1'b0, wo.pc} >= wo.el);
            end
            if (complete) begin
                if (wo.room < wo.el) begin
                    wo = f_terminate(wo);
                end else begin
                    held  = wo.pb;
                    n     = wo.pc;
                    k     = wo.el;
                    wo.pc = 2'd0;
                    wo.el = 3'd0;
                    for (i = 0; i < 3; i++) begin
                        if (2'(i) < n) begin
                            wo = f_emit(wo, held[i]);
                        end
                    end
                    if ({1'b0, n} < k) begin
                        wo = f_emit(wo, b);
                    end
                end
            end
        end else begin
            wo = f_flush(wo);
            if (!wo.stop) begin
                wo = f_take_lead(wo, b);
            end
        end
        return wo;
    endfunction

    always_comb
    begin
        if (room_reg[16] || (room_reg == 17'd0)) begin
            room_sat = 3'd0;
        end else if (room_reg[15:3] != 13'd0) begin
            room_sat = 3'd7;
        end else begin
            room_sat = room_reg[2:0];
        end
    end

    always_comb
    begin
        w       = '0;
        w.stop  = stopped_reg;
        w.pc    = pc_reg;
        w.el    = el_reg;
        w.pb    = pb_reg;
        w.room  = room_sat;
        clr     = 1'b0;
        if (cap_reg == 16'd0) begin
            clr = end_of_text;
        end else begin
            if (!w.stop && (w.room == 3'd0)) begin
                w = f_terminate(w);
            end
            if (byte_present && (data_byte != 8'h00) && !w.stop) begin
                w = f_take_byte(w, data_byte);
            end
            if (end_of_text) begin
                if (!w.stop) begin
                    w = f_flush(w);
                end
                if (!w.stop) begin
                    w = f_terminate(w);
                end
                clr = 1'b1;
            end
        end
    end

    always_comb
    begin
        cap_next     = cap_reg;
        wc_next      = wc_reg;
        room_next    = room_reg;
        stopped_next = stopped_reg;
        pc_next      = pc_reg;
        el_next      = el_reg;
        pb_next      = pb_reg;
        if (cfg_write) begin
            cap_next  = cfg_capacity;
            room_next = {1'b0, cfg_capacity} - 17'd1 - {1'b0, wc_reg};
        end else if (accept) begin
            pb_next = w.pb;
            if (clr) begin
                wc_next      = 16'd0;
                room_next    = {1'b0, cap_reg} - 17'd1;
                stopped_next = 1'b0;
                pc_next      = 2'd0;
                el_next      = 3'd0;
            end else begin
                wc_next      = wc_reg + 16'(w.nemit);
                room_next    = room_reg - 17'(w.nemit);
                stopped_next = w.stop;
                pc_next      = w.pc;
                el_next      = w.el;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg     <= CAPACITY_RESET;
            wc_reg      <= 16'd0;
            room_reg    <= 17'(CAPACITY_RESET) - 17'd1;
            stopped_reg <= 1'b0;
            pc_reg      <= 2'd0;
            el_reg      <= 3'd0;
        end else begin
            cap_reg     <= cap_next;
            wc_reg      <= wc_next;
            room_reg    <= room_next;
            stopped_reg <= stopped_next;
            pc_reg      <= pc_next;
            el_reg      <= el_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pb_reg <= pb_next;
    end

    always_comb
    begin
        push.valid     = accept && (w.cnt != '0);
        push.pkt.cnt   = w.cnt;
        push.pkt.bytes = w.ob;
        push.pkt.last  = w.ol;
    end

endmodule

// ===== rtl/core/utf8sbc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizing bounded copy: packet queue
// Small register FIFO of result packets between the front and back ends.
// ----------------------------------------------------------------------------
module utf8sbc_queue
    import utf8sbc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pkt_slot_t push,
    input  logic      pop,
    output logic      full,
    output pkt_slot_t head
);

    localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned QCNT_W = $clog2(DEPTH + 1);

    packet_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push.valid && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push.valid) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid) begin
            mem_reg[wr_ptr_reg] <= push.pkt;
        end
    end

    assign full       = (count_reg == QCNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.pkt   = mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/utf8sbc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 sanitizing bounded copy: back end
// Serializes the head packet one byte per cycle, unless stalled, to the output.
// ----------------------------------------------------------------------------
module utf8sbc_back
    import utf8sbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  pkt_slot_t  head,
    output logic       pop,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg, last_next;
    logic             load;

    // The output register takes a new item whenever it is empty or being taken.
    assign load = !valid_reg || !res_stall;
    assign pop  = load && head.valid && (idx_reg == head.pkt.cnt - 1'b1);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = head.valid;
            if (head.valid) begin
                byte_next = head.pkt.bytes[idx_reg];
                last_next = head.pkt.last[idx_reg];
                idx_next  = pop ? '0 : idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign res_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule
